/* rtl/pcpa_pkg.sv */
// Package for the PWM channel pair allocator: sizes, status codes,
// request and write-back structs shared by the control block and the top level.
// No dependencies.
package pcpa_pkg;

  // Sizing
  localparam int CHANNELS    = 16;
  localparam int MAX_PWM_PIN = 33;
  localparam int TIMERS      = (CHANNELS + 1) / 2;
  localparam int PAIR_W      = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam bit ODD_LAST    = (CHANNELS % 2) == 1;

  // Field widths
  localparam int PIN_W  = 6;
  localparam int FREQ_W = 26;
  localparam int RES_W  = 5;
  localparam int CHO_W  = 4;
  localparam int STS_W  = 3;

  // Memory words: owner row holds both channels of a pair, hi channel on top
  localparam int ROW_W = 2 * PIN_W;
  localparam int TMR_W = FREQ_W + RES_W;

  typedef enum logic [STS_W-1:0] {
    ST_INVALID  = 3'd0,
    ST_ATTACHED = 3'd1,
    ST_JOINED   = 3'd2,
    ST_NEWPAIR  = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  // Write-back command toward the two memories
  typedef struct packed {
    logic              owner_we;
    logic              timer_we;
    logic [PAIR_W-1:0] pair;
    logic [ROW_W-1:0]  owner_row;
    logic [TMR_W-1:0]  timer_word;
  } pcpa_wr_t;

  // Finished request toward the output register
  typedef struct packed {
    logic             done;
    logic [CHO_W-1:0] channel;
    status_t          status;
  } pcpa_res_t;

  // Channel number of (pair, lsb), kept to the low bits of the output field
  function automatic logic [CHO_W-1:0] chan_out(input logic [PAIR_W-1:0] pair,
                                                input logic lsb);
    logic [31:0] wide;
    wide = 32'({pair, lsb});
    return wide[CHO_W-1:0];
  endfunction

endpackage

/* rtl/pcpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pcpa_ctrl.sv */
// Request sequencer: walks the pair rows of the owner and timer memories,
// tracks the first hit of each rule, then writes back and finishes the request.
// Depends on pcpa_pkg.
module pcpa_ctrl
  import pcpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIN_W-1:0]  in_pin,
  input  logic [FREQ_W-1:0] in_freq,
  input  logic [RES_W-1:0]  in_res,
  input  logic              out_free,
  output logic              rd_en,
  output logic [PAIR_W-1:0] rd_pair,
  input  logic [ROW_W-1:0]  owner_rdata,
  input  logic [TMR_W-1:0]  timer_rdata,
  output pcpa_wr_t          wr,
  output pcpa_res_t         res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [PAIR_W-1:0] LAST = PAIR_W'(TIMERS - 1);

  state_t state_r, state_nxt;

  // Request under work
  logic [PIN_W-1:0]  pin_r;
  logic [FREQ_W-1:0] freq_r;
  logic [RES_W-1:0]  res_r;
  logic              bad_r, bad_nxt;

  // Read issue and check stages
  logic              iss_r, iss_nxt;
  logic [PAIR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              ck_vld_r, ck_vld_nxt;
  logic [PAIR_W-1:0] ck_idx_r;

  // First hit of each rule
  logic              att_f_r, att_f_nxt;
  logic [PAIR_W-1:0] att_pair_r;
  logic              att_lsb_r;
  logic              join_f_r, join_f_nxt;
  logic [PAIR_W-1:0] join_pair_r;
  logic              join_lsb_r;
  logic [ROW_W-1:0]  join_row_r;
  logic              pair_f_r, pair_f_nxt;
  logic [PAIR_W-1:0] pair_idx_r;

  // Busy bits per channel, one pair per word
  logic [1:0] chv_r [TIMERS];

  logic             accept;
  logic             pin_ok;
  logic             busy_lo, busy_hi, hi_exists, tmatch;
  logic             att_hit, att_lsb;
  logic             join_hit, join_lsb;
  logic             pair_hit;
  logic             finish;
  logic [PIN_W-1:0] row_lo, row_hi;

  assign accept = in_valid && in_ready;
  assign pin_ok = (in_pin != '0) && (in_pin <= PIN_W'(MAX_PWM_PIN));

  // Row check on the data returned from the memories
  always_comb begin
    row_lo    = owner_rdata[PIN_W-1:0];
    row_hi    = owner_rdata[ROW_W-1:PIN_W];
    busy_lo   = chv_r[ck_idx_r][0];
    busy_hi   = chv_r[ck_idx_r][1];
    hi_exists = !(ODD_LAST && (ck_idx_r == LAST));
    tmatch    = (timer_rdata == {freq_r, res_r});
    att_hit   = (busy_lo && (row_lo == pin_r)) || (busy_hi && (row_hi == pin_r));
    att_lsb   = !(busy_lo && (row_lo == pin_r));
    join_hit  = tmatch && ((!busy_lo && busy_hi) || (hi_exists && !busy_hi && busy_lo));
    join_lsb  = busy_lo;
    pair_hit  = !busy_lo && !busy_hi;
  end

  assign finish = (state_r == S_DONE) && out_free;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    bad_nxt    = bad_r;
    iss_nxt    = iss_r;
    rd_idx_nxt = rd_idx_r;
    ck_vld_nxt = 1'b0;
    att_f_nxt  = att_f_r;
    join_f_nxt = join_f_r;
    pair_f_nxt = pair_f_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          bad_nxt    = !pin_ok;
          iss_nxt    = pin_ok;
          rd_idx_nxt = '0;
          att_f_nxt  = 1'b0;
          join_f_nxt = 1'b0;
          pair_f_nxt = 1'b0;
          state_nxt  = pin_ok ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (iss_r) begin
          ck_vld_nxt = 1'b1;
          if (rd_idx_r == LAST) begin
            iss_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (ck_vld_r) begin
          if (att_hit) att_f_nxt = 1'b1;
          if (join_hit) join_f_nxt = 1'b1;
          if (pair_hit) pair_f_nxt = 1'b1;
          if (ck_idx_r == LAST) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bad_r    <= 1'b0;
      iss_r    <= 1'b0;
      rd_idx_r <= '0;
      ck_vld_r <= 1'b0;
      att_f_r  <= 1'b0;
      join_f_r <= 1'b0;
      pair_f_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bad_r    <= bad_nxt;
      iss_r    <= iss_nxt;
      rd_idx_r <= rd_idx_nxt;
      ck_vld_r <= ck_vld_nxt;
      att_f_r  <= att_f_nxt;
      join_f_r <= join_f_nxt;
      pair_f_r <= pair_f_nxt;
    end
  end

  // Busy bits: cleared by reset, set on a grant that takes a free channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIMERS; i++) begin
        chv_r[i] <= 2'b00;
      end
    end else if (finish && !bad_r && !att_f_r) begin
      if (join_f_r) begin
        chv_r[join_pair_r][join_lsb_r] <= 1'b1;
      end else if (pair_f_r) begin
        chv_r[pair_idx_r][0] <= 1'b1;
      end
    end
  end

  // Request and hit payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pin_r  <= in_pin;
      freq_r <= in_freq;
      res_r  <= in_res;
    end
    ck_idx_r <= rd_idx_r;
    if (state_r == S_SCAN && ck_vld_r) begin
      if (att_hit && !att_f_r) begin
        att_pair_r <= ck_idx_r;
        att_lsb_r  <= att_lsb;
      end
      if (join_hit && !join_f_r) begin
        join_pair_r <= ck_idx_r;
        join_lsb_r  <= join_lsb;
        join_row_r  <= owner_rdata;
      end
      if (pair_hit && !pair_f_r) begin
        pair_idx_r <= ck_idx_r;
      end
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign rd_en    = (state_r == S_SCAN) && iss_r;
  assign rd_pair  = rd_idx_r;

  // Decision and write-back, rules in priority order
  always_comb begin
    wr.owner_we   = 1'b0;
    wr.timer_we   = 1'b0;
    wr.pair       = pair_idx_r;
    wr.owner_row  = {{PIN_W{1'b0}}, pin_r};
    wr.timer_word = {freq_r, res_r};
    res.done      = finish;
    res.channel   = '0;
    res.status    = ST_NONE;
    if (bad_r) begin
      res.status = ST_INVALID;
    end else if (att_f_r) begin
      res.channel = chan_out(att_pair_r, att_lsb_r);
      res.status  = ST_ATTACHED;
    end else if (join_f_r) begin
      wr.owner_we  = finish;
      wr.pair      = join_pair_r;
      wr.owner_row = join_lsb_r ? {pin_r, join_row_r[PIN_W-1:0]}
                                : {join_row_r[ROW_W-1:PIN_W], pin_r};
      res.channel  = chan_out(join_pair_r, join_lsb_r);
      res.status   = ST_JOINED;
    end else if (pair_f_r) begin
      wr.owner_we = finish;
      wr.timer_we = finish;
      res.channel = chan_out(pair_idx_r, 1'b0);
      res.status  = ST_NEWPAIR;
    end
  end

endmodule

/* rtl/pwm_channel_pair_allocator_core.sv */
// Top level of the PWM channel pair allocator: owner and timer memories,
// request sequencer and the result register. Depends on pcpa_pkg, pcpa_ram, pcpa_ctrl.
//
// Each request (pin, freq, res) returns one result (channel, status). Channels
// are grouped in pairs sharing one timer; a pair's two owner pins sit in one word
// of the owner memory and its frequency/resolution in one word of the timer
// memory. A request with a valid pin walks the pair rows, one row per cycle through
// the single read port, checks each returned row and writes back once the result
// register is free; an invalid pin skips the walk. One request is in work at a
// time; a new request is taken while a finished result still waits in the result
// register. Channels are never released.
module pwm_channel_pair_allocator_core
  import pcpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIN_W-1:0]  in_pin,
  input  logic [FREQ_W-1:0] in_freq,
  input  logic [RES_W-1:0]  in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHO_W-1:0]  out_channel,
  output logic [STS_W-1:0]  out_status
);

  logic              rd_en;
  logic [PAIR_W-1:0] rd_pair;
  logic [ROW_W-1:0]  owner_rdata;
  logic [TMR_W-1:0]  timer_rdata;
  pcpa_wr_t          wr;
  pcpa_res_t         res;
  logic              out_free;

  logic              out_valid_r;
  logic [CHO_W-1:0]  out_channel_r;
  logic [STS_W-1:0]  out_status_r;

  // Owner pins, one pair per word
  pcpa_ram #(.WIDTH(ROW_W), .DEPTH(TIMERS)) u_owner_ram (
    .clk   (clk),
    .we    (wr.owner_we),
    .waddr (wr.pair),
    .wdata (wr.owner_row),
    .re    (rd_en),
    .raddr (rd_pair),
    .rdata (owner_rdata)
  );

  // Timer frequency and resolution, one timer per word
  pcpa_ram #(.WIDTH(TMR_W), .DEPTH(TIMERS)) u_timer_ram (
    .clk   (clk),
    .we    (wr.timer_we),
    .waddr (wr.pair),
    .wdata (wr.timer_word),
    .re    (rd_en),
    .raddr (rd_pair),
    .rdata (timer_rdata)
  );

  pcpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pin      (in_pin),
    .in_freq     (in_freq),
    .in_res      (in_res),
    .out_free    (out_free),
    .rd_en       (rd_en),
    .rd_pair     (rd_pair),
    .owner_rdata (owner_rdata),
    .timer_rdata (timer_rdata),
    .wr          (wr),
    .res         (res)
  );

  // Result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_channel_r <= res.channel;
      out_status_r  <= res.status;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_status  = out_status_r;

endmodule

/* rtl/pcpa_checker.sv */
// Port-level checker for the PWM channel pair allocator, bound to the top level.
// Depends on pcpa_pkg and pwm_channel_pair_allocator_core.
module pcpa_checker
  import pcpa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHO_W-1:0]  out_channel,
  input logic [STS_W-1:0]  out_status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_status))
    else $error("result changed while stalled");

  // Failures report channel zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_INVALID || out_status == ST_NONE) |-> out_channel == '0)
    else $error("failure status with nonzero channel");

  // One request in work at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pwm_channel_pair_allocator_core pcpa_checker u_pcpa_checker (.*);
